/* rtl/sdcd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdcd_pkg - SD clock divider select, shared types and constants
// Item types, divider handshake structs, sequencer states, and the
// elaboration-time helpers that build the prescaler candidate tables and the divisor mask.
// ----------------------------------------------------------------------------
package sdcd_pkg;

	localparam int DATA_W      = 32;
	localparam int PRE_W       = 10;  // prescaler up to 2*256
	localparam int PRE_MAX     = 512;
	localparam int DIV_LIST_N  = 32;  // no n <= 512 has more than 24 divisors
	localparam int K_W         = 5;
	localparam int DIV_FIELD_W = 4;
	localparam int PRE_FIELD_W = 8;
	localparam int DIV_MASK_W  = 17;  // ratios 0..16
	localparam int RATIO_IDX_W = 5;

	typedef struct packed {
		logic [DATA_W-1:0] source_hz;
		logic [DATA_W-1:0] target_hz;
	} in_item_t;

	typedef struct packed {
		logic [DIV_FIELD_W-1:0] divisor_field;
		logic [PRE_FIELD_W-1:0] prescaler_field;
		logic [DATA_W-1:0]      achieved_hz;
		logic                   range_error;
	} out_item_t;

	typedef struct packed {
		logic              start;
		logic [DATA_W-1:0] dividend;
		logic [DATA_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DATA_W-1:0] quotient;
	} div_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RATIO,
		ST_CHECK,
		ST_SEARCH,
		ST_CEIL,
		ST_HZ,
		ST_DONE
	} state_t;

	typedef logic [DIV_LIST_N-1:0][PRE_W-1:0] div_list_t;

	// Divisors of lim in ascending order, zero padded. Built by repeated add.
	function automatic div_list_t divisor_list(input int unsigned lim);
		div_list_t   lst;
		int unsigned n;
		int unsigned m;
		int unsigned cand;
		lst = '0;
		n   = 0;
		for (cand = 1; cand <= PRE_MAX; cand++) begin
			m = cand;
			while (m < lim) begin
				m += cand;
			end
			if (m == lim && n < DIV_LIST_N) begin
				lst[n] = PRE_W'(cand);
				n++;
			end
		end
		return lst;
	endfunction

	// Bit r set when r divides md, for r in 1..16.
	function automatic logic [DIV_MASK_W-1:0] divides_mask(input int unsigned md);
		logic [DIV_MASK_W-1:0] mask;
		int unsigned           m;
		int unsigned           r;
		mask = '0;
		for (r = 1; r < DIV_MASK_W; r++) begin
			m = r;
			while (m < md) begin
				m += r;
			end
			mask[r] = (m == md);
		end
		return mask;
	endfunction

endpackage

/* rtl/sdcd_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdcd_div - shared restoring divider
// Unsigned 32 / 32 bit divide, one quotient bit per cycle. Done pulses once
// the last quotient bit is in, with the quotient held until the next start.
// ----------------------------------------------------------------------------
module sdcd_div (
	input  logic               clk,
	input  logic               arst_n,
	input  sdcd_pkg::div_req_t req,
	output sdcd_pkg::div_rsp_t rsp
);

	localparam int DATA_W = sdcd_pkg::DATA_W;
	localparam int CNT_W  = $clog2(DATA_W + 1);

	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] dvs_q;

	logic [DATA_W:0]   shifted;
	logic [DATA_W:0]   diff;

	assign shifted = {rem_q, quo_q[DATA_W-1]};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= CNT_W'(DATA_W);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - CNT_W'(1);
				done_q <= (cnt_q == CNT_W'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (cnt_q != '0) begin
			if (!diff[DATA_W]) begin
				rem_q <= diff[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

/* rtl/sdcd_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdcd_ctrl - divider selection sequencer
// Walks one item through ratio, round-up check, prescaler search, divisor
// ceiling and achieved frequency, issuing each divide to the shared unit.
// ----------------------------------------------------------------------------
module sdcd_ctrl #(
	parameter int unsigned MAX_DIVISOR   = 16,
	parameter int unsigned MAX_PRESCALER = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  sdcd_pkg::in_item_t  item,
	input  logic                ddr_mode,
	output logic                idle,
	output logic                res_valid,
	input  logic                res_ready,
	output sdcd_pkg::out_item_t res,
	output sdcd_pkg::div_req_t  div_req,
	input  sdcd_pkg::div_rsp_t  div_rsp
);

	localparam int DATA_W      = sdcd_pkg::DATA_W;
	localparam int PRE_W       = sdcd_pkg::PRE_W;
	localparam int K_W         = sdcd_pkg::K_W;
	localparam int DIV_FIELD_W = sdcd_pkg::DIV_FIELD_W;
	localparam int PRE_FIELD_W = sdcd_pkg::PRE_FIELD_W;
	localparam int RATIO_IDX_W = sdcd_pkg::RATIO_IDX_W;
	localparam int DW          = $clog2(MAX_DIVISOR + 1);
	localparam int DP_W        = DW + PRE_W;

	localparam logic [DATA_W-1:0] MD_W = DATA_W'(MAX_DIVISOR);
	localparam logic [DATA_W-1:0] SPAN_SDR = DATA_W'(MAX_DIVISOR * MAX_PRESCALER);
	localparam logic [DATA_W-1:0] SPAN_DDR = DATA_W'(2 * MAX_DIVISOR * MAX_PRESCALER);
	localparam logic [DIV_FIELD_W-1:0] SAT_DIV = DIV_FIELD_W'(MAX_DIVISOR - 1);
	localparam logic [PRE_FIELD_W-1:0] SAT_PRE = PRE_FIELD_W'(MAX_PRESCALER / 2);
	localparam logic [sdcd_pkg::DIV_MASK_W-1:0] DIV_OK =
		sdcd_pkg::divides_mask(MAX_DIVISOR);
	localparam sdcd_pkg::div_list_t PRE_SDR = sdcd_pkg::divisor_list(MAX_PRESCALER);
	localparam sdcd_pkg::div_list_t PRE_DDR = sdcd_pkg::divisor_list(2 * MAX_PRESCALER);

	sdcd_pkg::state_t    state_q, state_d;
	logic [K_W-1:0]      k_q;
	logic [DATA_W-1:0]   src_q;
	logic [DATA_W-1:0]   tgt_q;
	logic [DATA_W-1:0]   ratio_q;
	logic [PRE_W-1:0]    p_q;
	sdcd_pkg::out_item_t res_q;

	logic                done;
	logic [DATA_W-1:0]   q;
	logic [DATA_W-1:0]   span;
	logic [DATA_W-1:0]   ratio_up;
	logic                small_ratio;
	logic                refine;
	logic [DATA_W-1:0]   ratio_sh;
	logic [PRE_W-1:0]    pre_cand;
	logic                pre_cover;
	logic                search_fail;
	logic                search_hit;
	logic [DW-1:0]       d_next;
	logic [DP_W-1:0]     dp;
	logic [PRE_W-1:0]    p_sh;

	assign done        = div_rsp.done;
	assign q           = div_rsp.quotient;
	assign span        = ddr_mode ? SPAN_DDR : SPAN_SDR;
	assign refine      = (q > tgt_q);
	assign ratio_up    = refine ? ratio_q + DATA_W'(1) : ratio_q;
	assign small_ratio = (ratio_up <= MD_W);
	assign ratio_sh    = ddr_mode ? (ratio_up >> 2) : (ratio_up >> 1);
	assign pre_cand    = ddr_mode ? PRE_DDR[k_q] : PRE_SDR[k_q];
	assign pre_cover   = ((DATA_W'(pre_cand) * MD_W) >= ratio_q);
	// candidate list is zero padded past its last divisor
	assign search_fail = (pre_cand == '0) || (!pre_cover && (k_q == '1));
	assign search_hit  = !search_fail && pre_cover;
	assign d_next      = q[DW-1:0] + DW'(1);
	assign dp          = DP_W'(d_next) * DP_W'(p_q);
	assign p_sh        = ddr_mode ? (p_q >> 2) : (p_q >> 1);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sdcd_pkg::ST_IDLE: begin
				if (start) begin
					state_d = (item.target_hz == '0) ? sdcd_pkg::ST_HZ : sdcd_pkg::ST_RATIO;
				end
			end
			sdcd_pkg::ST_RATIO: begin
				if (done) begin
					state_d = (q == '0) ? sdcd_pkg::ST_DONE : sdcd_pkg::ST_CHECK;
				end
			end
			sdcd_pkg::ST_CHECK: begin
				if (done) begin
					if (!small_ratio) begin
						state_d = sdcd_pkg::ST_SEARCH;
					end else if (refine) begin
						state_d = sdcd_pkg::ST_HZ;
					end else begin
						state_d = sdcd_pkg::ST_DONE;
					end
				end
			end
			sdcd_pkg::ST_SEARCH: begin
				if (search_fail) begin
					state_d = sdcd_pkg::ST_HZ;
				end else if (search_hit) begin
					state_d = sdcd_pkg::ST_CEIL;
				end
			end
			sdcd_pkg::ST_CEIL: begin
				if (done) begin
					state_d = sdcd_pkg::ST_HZ;
				end
			end
			sdcd_pkg::ST_HZ: begin
				if (done) begin
					state_d = sdcd_pkg::ST_DONE;
				end
			end
			sdcd_pkg::ST_DONE: begin
				if (res_ready) begin
					state_d = sdcd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sdcd_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs and divide requests
	always_comb begin
		div_req   = '0;
		idle      = 1'b0;
		res_valid = 1'b0;
		case (state_q)
			sdcd_pkg::ST_IDLE: begin
				idle = 1'b1;
				if (start) begin
					div_req.start    = 1'b1;
					div_req.dividend = item.source_hz;
					div_req.divisor  = (item.target_hz == '0) ? span : item.target_hz;
				end
			end
			sdcd_pkg::ST_RATIO: begin
				if (done && q != '0) begin
					div_req.start    = 1'b1;
					div_req.dividend = src_q;
					div_req.divisor  = q;
				end
			end
			sdcd_pkg::ST_CHECK: begin
				if (done && small_ratio && refine) begin
					div_req.start    = 1'b1;
					div_req.dividend = src_q;
					div_req.divisor  = ratio_up;
				end
			end
			sdcd_pkg::ST_SEARCH: begin
				if (search_fail) begin
					div_req.start    = 1'b1;
					div_req.dividend = src_q;
					div_req.divisor  = span;
				end else if (search_hit) begin
					// ceil(ratio / p) = (ratio - 1) / p + 1
					div_req.start    = 1'b1;
					div_req.dividend = ratio_q - DATA_W'(1);
					div_req.divisor  = DATA_W'(pre_cand);
				end
			end
			sdcd_pkg::ST_CEIL: begin
				if (done) begin
					div_req.start    = 1'b1;
					div_req.dividend = src_q;
					div_req.divisor  = DATA_W'(dp);
				end
			end
			sdcd_pkg::ST_HZ: begin
			end
			sdcd_pkg::ST_DONE: begin
				res_valid = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sdcd_pkg::ST_IDLE;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == sdcd_pkg::ST_CHECK) begin
				k_q <= '0;
			end else if (state_q == sdcd_pkg::ST_SEARCH && !search_fail && !pre_cover) begin
				k_q <= k_q + K_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			sdcd_pkg::ST_IDLE: begin
				if (start) begin
					src_q <= item.source_hz;
					tgt_q <= item.target_hz;
					res_q.divisor_field   <= SAT_DIV;
					res_q.prescaler_field <= SAT_PRE;
					res_q.range_error     <= (item.target_hz == '0);
				end
			end
			sdcd_pkg::ST_RATIO: begin
				if (done) begin
					ratio_q <= q;
					res_q.divisor_field   <= '0;
					res_q.prescaler_field <= '0;
					res_q.achieved_hz     <= src_q;
					res_q.range_error     <= 1'b0;
				end
			end
			sdcd_pkg::ST_CHECK: begin
				if (done) begin
					ratio_q           <= ratio_up;
					res_q.achieved_hz <= q;
					if (DIV_OK[ratio_up[RATIO_IDX_W-1:0]]) begin
						res_q.divisor_field   <= '0;
						res_q.prescaler_field <= ratio_sh[PRE_FIELD_W-1:0];
					end else begin
						res_q.divisor_field   <= DIV_FIELD_W'(ratio_up - DATA_W'(1));
						res_q.prescaler_field <= '0;
					end
				end
			end
			sdcd_pkg::ST_SEARCH: begin
				if (search_fail) begin
					res_q.divisor_field   <= SAT_DIV;
					res_q.prescaler_field <= SAT_PRE;
					res_q.range_error     <= 1'b1;
				end else if (search_hit) begin
					p_q <= pre_cand;
				end
			end
			sdcd_pkg::ST_CEIL: begin
				if (done) begin
					// quotient is already divisor minus one
					res_q.divisor_field   <= q[DIV_FIELD_W-1:0];
					res_q.prescaler_field <= p_sh[PRE_FIELD_W-1:0];
				end
			end
			sdcd_pkg::ST_HZ: begin
				if (done) begin
					res_q.achieved_hz <= q;
				end
			end
			sdcd_pkg::ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	assign res = res_q;

endmodule

/* rtl/sd_clock_divider_select_core.sv */
`timescale 1ns / 1ps
// Each item runs one to four divides on the shared 32-bit restoring divider, plus
//   a prescaler candidate search when the ratio exceeds the divisor.
// Throughput: one item at a time; item_ready is low until the sequencer idles.
// Reset: arst_n clears the sequencer, output valid and ddr_mode to 0.
// ----------------------------------------------------------------------------
// sd_clock_divider_select_core - SD bus clock divider selection
// Picks divisor and prescaler fields for a wanted bus clock, reports the
// achieved frequency and flags requests outside the divider range.
// ----------------------------------------------------------------------------
module sd_clock_divider_select_core #(
	parameter int unsigned MAX_DIVISOR   = 16,
	parameter int unsigned MAX_PRESCALER = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  sdcd_pkg::in_item_t  item,
	output logic                result_valid,
	input  logic                result_ready,
	output sdcd_pkg::out_item_t result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_data
);

	logic                ddr_mode_q;
	logic                result_valid_q;
	sdcd_pkg::out_item_t result_q;

	logic                start;
	logic                idle;
	logic                res_valid;
	logic                res_ready;
	sdcd_pkg::out_item_t res;
	sdcd_pkg::div_req_t  div_req;
	sdcd_pkg::div_rsp_t  div_rsp;

	assign cfg_ready  = 1'b1;
	assign item_ready = idle;
	assign start      = item_valid && item_ready;
	// output register frees the sequencer when the slot is empty or its result is taken
	assign res_ready  = !result_valid_q || result_ready;

	sdcd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	sdcd_ctrl #(
		.MAX_DIVISOR   (MAX_DIVISOR),
		.MAX_PRESCALER (MAX_PRESCALER)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.ddr_mode  (ddr_mode_q),
		.idle      (idle),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.div_req   (div_req),
		.div_rsp   (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ddr_mode_q     <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				ddr_mode_q <= cfg_data;
			end
			if (res_ready) begin
				result_valid_q <= res_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			result_q <= res;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

/* rtl/sdcd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdcd_checker - port-level checks for the divider select core
// Tracks items in flight and checks result stability and saturation.
// ----------------------------------------------------------------------------
module sdcd_checker #(
	parameter int unsigned MAX_DIVISOR   = 16,
	parameter int unsigned MAX_PRESCALER = 256
) (
	input logic                clk,
	input logic                arst_n,
	input logic                item_valid,
	input logic                item_ready,
	input logic                result_valid,
	input logic                result_ready,
	input sdcd_pkg::out_item_t result
);

	localparam logic [sdcd_pkg::DIV_FIELD_W-1:0] SAT_DIV =
		sdcd_pkg::DIV_FIELD_W'(MAX_DIVISOR - 1);
	localparam logic [sdcd_pkg::PRE_FIELD_W-1:0] SAT_PRE =
		sdcd_pkg::PRE_FIELD_W'(MAX_PRESCALER / 2);

	logic [1:0] pending_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = item_valid && item_ready;
	assign out_acc = result_valid && result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + {1'b0, in_acc} - {1'b0, out_acc};
		end
	end

	// sequencer leaves idle once it takes an item, so item_ready drops
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !item_ready)
		else $error("item_ready high right after an accepted item");

	a_no_spurious_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> pending_q != 2'd0)
		else $error("result without an outstanding item");

	a_bounded_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3)
		else $error("more than two items in flight");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("stalled result changed");

	a_error_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.range_error |->
			result.divisor_field == SAT_DIV && result.prescaler_field == SAT_PRE)
		else $error("range error result not saturated");

endmodule

bind sd_clock_divider_select_core sdcd_checker #(
	.MAX_DIVISOR   (MAX_DIVISOR),
	.MAX_PRESCALER (MAX_PRESCALER)
) u_sdcd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

/* dv/sd_clock_divider_select_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sd_clock_divider_select_core_tb - divider selection self-checking bench
// Sends clock requests through the item handshake with random gaps and result
// back-pressure, toggles DDR mode between phases, and checks every divisor,
// prescaler, achieved frequency and range flag against an in-bench predictor.
// ----------------------------------------------------------------------------
module sd_clock_divider_select_core_tb;

	localparam int unsigned MAX_DIVISOR   = 16;
	localparam int unsigned MAX_PRESCALER = 256;
	localparam int unsigned CYCLE_LIMIT   = 1_000_000;
	localparam int unsigned TAIL_CYCLES   = 200;

	class divider_scoreboard;
		sdcd_pkg::out_item_t expected_q[$];
		bit                  ddr;
		int unsigned         errors;
		int unsigned         n_checked;
		int unsigned         n_range_err;
		int unsigned         n_ddr;
		int unsigned         n_bypass;

		function void set_ddr(bit v);
			ddr = v;
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		// Divider selection for one request under the current DDR setting.
		function sdcd_pkg::out_item_t expected_divider(sdcd_pkg::in_item_t req);
			longint unsigned     src;
			longint unsigned     tgt;
			longint unsigned     lim;
			longint unsigned     ratio;
			longint unsigned     p;
			longint unsigned     d;
			longint unsigned     first;
			int unsigned         shift;
			sdcd_pkg::out_item_t r;
			src   = req.source_hz;
			tgt   = req.target_hz;
			lim   = MAX_PRESCALER;
			shift = 1;
			if (ddr) begin
				lim   = lim * 2;
				shift = 2;
			end
			// saturated answer, used for zero target and out-of-range ratio
			r.divisor_field   = 4'(MAX_DIVISOR - 1);
			r.prescaler_field = 8'(lim >> shift);
			r.achieved_hz     = 32'(src / MAX_DIVISOR / lim);
			r.range_error     = 1'b1;
			if (tgt == 0)
				return r;
			ratio = src / tgt;
			if (ratio == 0) begin
				r.divisor_field   = '0;
				r.prescaler_field = '0;
				r.achieved_hz     = 32'(src);
				r.range_error     = 1'b0;
				return r;
			end
			if (src / ratio > tgt)
				ratio++;
			if (ratio <= MAX_DIVISOR) begin
				r.range_error = 1'b0;
				r.achieved_hz = 32'(src / ratio);
				if ((MAX_DIVISOR % ratio) == 0) begin
					r.divisor_field   = '0;
					r.prescaler_field = 8'(ratio >> shift);
				end else begin
					r.divisor_field   = 4'(ratio - 1);
					r.prescaler_field = '0;
				end
				return r;
			end
			first = ratio / MAX_DIVISOR;
			if (first < 2)
				first = 2;
			// skip candidates that would leave the divisor unencodable
			for (p = first; p <= lim; p++) begin
				if ((lim % p) != 0)
					continue;
				d = (ratio + p - 1) / p;
				if (d <= MAX_DIVISOR) begin
					r.divisor_field   = 4'(d - 1);
					r.prescaler_field = 8'(p >> shift);
					r.achieved_hz     = 32'(src / d / p);
					r.range_error     = 1'b0;
					return r;
				end
			end
			return r;
		endfunction

		function void note_request(sdcd_pkg::in_item_t req);
			sdcd_pkg::out_item_t e;
			e = expected_divider(req);
			expected_q.push_back(e);
			if (ddr)
				n_ddr++;
			if (e.range_error)
				n_range_err++;
			if (req.target_hz != 0 && req.source_hz < req.target_hz)
				n_bypass++;
		endfunction

		function void check_result(sdcd_pkg::out_item_t got);
			sdcd_pkg::out_item_t e;
			if (expected_q.size() == 0) begin
				$error("unexpected result item: div=%0d pre=%0d hz=%0d err=%0b",
					got.divisor_field, got.prescaler_field, got.achieved_hz,
					got.range_error);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			n_checked++;
			if (got.divisor_field !== e.divisor_field) begin
				$error("divisor_field: expected %0d, got %0d", e.divisor_field,
					got.divisor_field);
				errors++;
			end
			if (got.prescaler_field !== e.prescaler_field) begin
				$error("prescaler_field: expected %0d, got %0d", e.prescaler_field,
					got.prescaler_field);
				errors++;
			end
			if (got.achieved_hz !== e.achieved_hz) begin
				$error("achieved_hz: expected %0d, got %0d", e.achieved_hz,
					got.achieved_hz);
				errors++;
			end
			if (got.range_error !== e.range_error) begin
				$error("range_error: expected %0b, got %0b", e.range_error,
					got.range_error);
				errors++;
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                item_valid;
	logic                item_ready;
	sdcd_pkg::in_item_t  item;
	logic                result_valid;
	logic                result_ready;
	sdcd_pkg::out_item_t result;
	logic                cfg_valid;
	logic                cfg_ready;
	logic                cfg_data;

	divider_scoreboard sb = new();

	bit          tx_gaps;
	bit          rx_stalls;
	int unsigned hold_cycles;
	int unsigned cycles;
	int unsigned n_sent;

	sd_clock_divider_select_core #(
		.MAX_DIVISOR   (MAX_DIVISOR),
		.MAX_PRESCALER (MAX_PRESCALER)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			sb.check_result(result);
	end

	// result side: random stalls, plus one long hold requested by the main flow
	initial begin
		int unsigned n;
		result_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_cycles != 0) begin
				n           = hold_cycles;
				hold_cycles = 0;
				result_ready <= 1'b0;
				repeat (n - 1) @(negedge clk);
			end else if (rx_stalls && $urandom_range(0, 7) == 0) begin
				result_ready <= 1'b0;
				repeat ($urandom_range(1, 18) - 1) @(negedge clk);
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_request(input sdcd_pkg::in_item_t req);
		if (tx_gaps && $urandom_range(0, 5) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		item_valid <= 1'b1;
		item       <= req;
		do @(posedge clk); while (!item_ready);
		sb.note_request(req);
		n_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
	endtask

	// Only called with the block idle and item_valid low.
	task automatic write_ddr(input bit v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		sb.set_ddr(v);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic sdcd_pkg::in_item_t make_req(input logic [31:0] src,
		input logic [31:0] tgt);
		sdcd_pkg::in_item_t r;
		r.source_hz = src;
		r.target_hz = tgt;
		return r;
	endfunction

	// Half with a controlled ratio, the rest raw noise, edge targets and sources below target.
	function automatic sdcd_pkg::in_item_t random_request();
		int unsigned        sel;
		longint unsigned    tgt;
		longint unsigned    ratio;
		longint unsigned    src;
		sdcd_pkg::in_item_t r;
		sel = $urandom_range(0, 99);
		if (sel < 25) begin
			r = make_req($urandom, $urandom);
		end else if (sel < 75) begin
			case ($urandom_range(0, 2))
				0: ratio = $urandom_range(1, 16);
				1: ratio = $urandom_range(17, 600);
				default: ratio = $urandom_range(1, 9000);
			endcase
			tgt = $urandom >> $urandom_range(0, 31);
			while (tgt * ratio > 64'hFFFF_FFFF)
				tgt = tgt >> 1;
			if (tgt == 0)
				tgt = 1;
			src = tgt * ratio + ($urandom % tgt);
			if (src > 64'hFFFF_FFFF)
				src = 64'hFFFF_FFFF;
			r = make_req(32'(src), 32'(tgt));
		end else if (sel < 85) begin
			r = make_req($urandom, $urandom_range(0, 3));
		end else begin
			tgt = $urandom;
			r   = make_req(32'($urandom % (tgt == 0 ? 1 : tgt)), 32'(tgt));
		end
		return r;
	endfunction

	task automatic run_directed();
		int unsigned k;
		send_request(make_req(32'd0, 32'd0));
		send_request(make_req(32'hFFFF_FFFF, 32'd0));
		send_request(make_req(32'd0, 32'hFFFF_FFFF));
		send_request(make_req(32'd5, 32'd10));
		send_request(make_req(32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send_request(make_req(32'd100, 32'd30));        // rounded-up ratio
		for (k = 2; k <= MAX_DIVISOR; k++)
			send_request(make_req(32'(k * 1_000_000), 32'd1_000_000));
		send_request(make_req(32'd33, 32'd1));          // first prescaler too small
		send_request(make_req(32'd4096, 32'd1));
		send_request(make_req(32'd8192, 32'd1));
		send_request(make_req(32'hFFFF_FFFF, 32'd1));   // out of range
	endtask

	task automatic run_random(input int unsigned count);
		repeat (count) send_request(random_request());
	endtask

	initial begin
		arst_n      = 1'b0;
		item_valid  = 1'b0;
		item        = '0;
		cfg_valid   = 1'b0;
		cfg_data    = 1'b0;
		tx_gaps     = 1'b1;
		rx_stalls   = 1'b1;
		hold_cycles = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		write_ddr(1'b0);
		run_directed();
		wait_drained();
		write_ddr(1'b1);
		run_directed();
		wait_drained();

		run_random(150);
		// long back-pressure while requests keep coming
		hold_cycles = 400;
		run_random(150);
		wait_drained();
		write_ddr(1'b0);
		run_random(150);
		wait_drained();
		run_random(150);
		wait_drained();
		write_ddr(1'b1);
		run_random(50);
		tx_gaps   = 1'b0;
		rx_stalls = 1'b0;
		run_random(150);
		wait_drained();

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Sent %0d requests, checked %0d results (%0d in DDR mode).",
			n_sent, sb.n_checked, sb.n_ddr);
		$display("Range-error results: %0d, source-below-target: %0d, cycles: %0d.",
			sb.n_range_err, sb.n_bypass, cycles);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
